### rtl/cgps_pkg.sv
// Package for the central gravity particle step block.
// Holds the item, result, configuration and context types, register map and helpers.
// No dependencies.
`default_nettype none

package cgps_pkg;

	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_TIME_STEP   = 3'd0;
	localparam logic [2:0] REG_CENTER_X    = 3'd1;
	localparam logic [2:0] REG_CENTER_Y    = 3'd2;
	localparam logic [2:0] REG_PULL        = 3'd3;
	localparam logic [2:0] REG_HORIZON     = 3'd4;

	localparam logic [12:0] RST_TIME_STEP  = 13'd1092;
	localparam logic [23:0] RST_CENTER_X   = 24'd153600;
	localparam logic [23:0] RST_CENTER_Y   = 24'd102400;
	localparam logic [26:0] RST_PULL       = 27'd50000000;
	localparam logic [9:0]  RST_HORIZON    = 10'd50;

	localparam int SQ_W    = 50;
	localparam int DIST_W  = 25;
	localparam int QUO_W   = 53;
	localparam int GRAV_W  = 40;
	localparam int GRAV_SH = 22;
	localparam int MNUM_W  = 58;
	localparam int QLO_W   = 27;

	localparam logic [DIST_W-1:0] DIST_MIN = 25'd26;

	typedef struct packed {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] vel_x;
		logic signed [23:0] vel_y;
		logic [25:0]        life_left;
	} particle_t;

	typedef struct packed {
		logic signed [23:0] new_pos_x;
		logic signed [23:0] new_pos_y;
		logic signed [23:0] new_vel_x;
		logic signed [23:0] new_vel_y;
		logic [25:0]        new_life;
		logic               alive;
	} result_t;

	typedef struct packed {
		logic [12:0]        time_step;
		logic signed [23:0] center_x;
		logic signed [23:0] center_y;
		logic [26:0]        pull_strength;
		logic [9:0]         horizon_radius;
	} cfg_t;

	typedef struct packed {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] vel_x;
		logic signed [23:0] vel_y;
		logic [25:0]        life;
		logic               neg_x;
		logic               neg_y;
		logic [23:0]        mag_x;
		logic [23:0]        mag_y;
		logic [DIST_W-1:0]  radius;
	} ctx_t;

	function automatic logic signed [23:0] sat24(input logic signed [41:0] v);
		logic signed [23:0] r;
		if (v > 42'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -42'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	function automatic logic signed [23:0] vel_step(input logic [QUO_W-1:0] m, input logic neg,
			input logic signed [23:0] vel);
		logic [QUO_W:0]     rnd;
		logic [39:0]        dv;
		logic signed [41:0] dvs;
		logic signed [41:0] sum;
		rnd = {1'b0, m} + 54'd8192;
		dv  = rnd[53:14];
		dvs = $signed({2'b00, dv});
		sum = neg ? (42'(vel) - dvs) : (42'(vel) + dvs);
		return sat24(sum);
	endfunction

	function automatic logic signed [23:0] pos_step(input logic [36:0] prod, input logic neg,
			input logic signed [23:0] pos);
		logic [37:0]        rnd;
		logic signed [41:0] dps;
		logic signed [41:0] sum;
		rnd = {1'b0, prod} + 38'd32768;
		dps = $signed({20'd0, rnd[37:16]});
		sum = neg ? (42'(pos) - dps) : (42'(pos) + dps);
		return sat24(sum);
	endfunction

endpackage

`default_nettype wire

### rtl/cgps_cfg.sv
// Configuration register file on an APB-style port.
// Depends on cgps_pkg for the register map, reset values and cfg_t.
`default_nettype none

module cgps_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [cgps_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output cgps_pkg::cfg_t                   cfg
);

	cgps_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step      <= cgps_pkg::RST_TIME_STEP;
			cfg_q.center_x       <= cgps_pkg::RST_CENTER_X;
			cfg_q.center_y       <= cgps_pkg::RST_CENTER_Y;
			cfg_q.pull_strength  <= cgps_pkg::RST_PULL;
			cfg_q.horizon_radius <= cgps_pkg::RST_HORIZON;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[cgps_pkg::ADDR_W-1:2])
				cgps_pkg::REG_TIME_STEP: cfg_q.time_step      <= pwdata[12:0];
				cgps_pkg::REG_CENTER_X:  cfg_q.center_x       <= pwdata[23:0];
				cgps_pkg::REG_CENTER_Y:  cfg_q.center_y       <= pwdata[23:0];
				cgps_pkg::REG_PULL:      cfg_q.pull_strength  <= pwdata[26:0];
				cgps_pkg::REG_HORIZON:   cfg_q.horizon_radius <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[cgps_pkg::ADDR_W-1:2])
			cgps_pkg::REG_TIME_STEP: prdata = {19'd0, cfg_q.time_step};
			cgps_pkg::REG_CENTER_X:  prdata = {{8{cfg_q.center_x[23]}}, cfg_q.center_x};
			cgps_pkg::REG_CENTER_Y:  prdata = {{8{cfg_q.center_y[23]}}, cfg_q.center_y};
			cgps_pkg::REG_PULL:      prdata = {5'd0, cfg_q.pull_strength};
			cgps_pkg::REG_HORIZON:   prdata = {22'd0, cfg_q.horizon_radius};
			default:                 prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign cfg    = cfg_q;

endmodule

`default_nettype wire

### rtl/cgps_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries a tag alongside each item; no package dependencies.
`default_nettype none

module cgps_isqrt #(
	parameter int IN_W  = 50,
	parameter int PAY_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire logic [IN_W-1:0]   sq,
	input  wire logic [PAY_W-1:0]  tag,
	output logic                   root_valid,
	output logic [IN_W/2-1:0]      root,
	output logic [PAY_W-1:0]       root_tag
);

	localparam int ROOT_W = IN_W / 2;
	localparam int REM_W  = ROOT_W + 1;

	logic              valid_s [ROOT_W];
	logic [IN_W-1:0]   sq_s    [ROOT_W];
	logic [REM_W-1:0]  rem_s   [ROOT_W];
	logic [ROOT_W-1:0] root_s  [ROOT_W];
	logic [PAY_W-1:0]  tag_s   [ROOT_W];

	for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
		logic              p_valid;
		logic [IN_W-1:0]   p_sq;
		logic [REM_W-1:0]  p_rem;
		logic [ROOT_W-1:0] p_root;
		logic [PAY_W-1:0]  p_tag;
		logic [REM_W+1:0]  cur;
		logic [REM_W+1:0]  trial;
		logic [REM_W+1:0]  diff;
		logic              ge;

		if (i == 0) begin : g_head
			assign p_valid = item_valid;
			assign p_sq    = sq;
			assign p_rem   = '0;
			assign p_root  = '0;
			assign p_tag   = tag;
		end else begin : g_body
			assign p_valid = valid_s[i-1];
			assign p_sq    = sq_s[i-1];
			assign p_rem   = rem_s[i-1];
			assign p_root  = root_s[i-1];
			assign p_tag   = tag_s[i-1];
		end

		assign cur   = {p_rem, p_sq[IN_W-1-2*i -: 2]};
		assign trial = {1'b0, p_root, 2'b01};
		assign diff  = cur - trial;
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else begin
				valid_s[i] <= p_valid;
			end
		end

		always_ff @(posedge clk) begin
			sq_s[i]   <= p_sq;
			rem_s[i]  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
			root_s[i] <= {p_root[ROOT_W-2:0], ge};
			tag_s[i]  <= p_tag;
		end
	end

	assign root_valid = valid_s[ROOT_W-1];
	assign root       = root_s[ROOT_W-1];
	assign root_tag   = tag_s[ROOT_W-1];

endmodule

`default_nettype wire

### rtl/cgps_div.sv
// Pipelined restoring divider, one quotient bit per register stage, several lanes
// sharing one divisor. Carries a tag alongside each item; no package dependencies.
`default_nettype none

module cgps_div #(
	parameter int NUM_W = 62,
	parameter int DEN_W = 50,
	parameter int QUO_W = 53,
	parameter int LANES = 1,
	parameter int PAY_W = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	input  wire logic [LANES-1:0][NUM_W-1:0]  num,
	input  wire logic [DEN_W-1:0]             den,
	input  wire logic [PAY_W-1:0]             tag,
	output logic                              quo_valid,
	output logic [LANES-1:0][QUO_W-1:0]       quo,
	output logic [PAY_W-1:0]                  quo_tag
);

	localparam int HEAD_W = NUM_W - QUO_W;

	logic                        valid_s [QUO_W];
	logic [DEN_W-1:0]            den_s   [QUO_W];
	logic [PAY_W-1:0]            tag_s   [QUO_W];
	logic [LANES-1:0][DEN_W-1:0] rem_s   [QUO_W];
	logic [LANES-1:0][QUO_W-1:0] lo_s    [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		logic                        p_valid;
		logic [DEN_W-1:0]            p_den;
		logic [PAY_W-1:0]            p_tag;
		logic [LANES-1:0][DEN_W-1:0] p_rem;
		logic [LANES-1:0][QUO_W-1:0] p_lo;
		logic [LANES-1:0][DEN_W-1:0] n_rem;
		logic [LANES-1:0][QUO_W-1:0] n_lo;

		if (i == 0) begin : g_head
			assign p_valid = item_valid;
			assign p_den   = den;
			assign p_tag   = tag;
			for (genvar j = 0; j < LANES; j++) begin : g_lane
				assign p_rem[j] = {{(DEN_W-HEAD_W){1'b0}}, num[j][NUM_W-1:QUO_W]};
				assign p_lo[j]  = num[j][QUO_W-1:0];
			end
		end else begin : g_body
			assign p_valid = valid_s[i-1];
			assign p_den   = den_s[i-1];
			assign p_tag   = tag_s[i-1];
			assign p_rem   = rem_s[i-1];
			assign p_lo    = lo_s[i-1];
		end

		for (genvar j = 0; j < LANES; j++) begin : g_sub
			logic [DEN_W:0] cur;
			logic [DEN_W:0] diff;
			logic           ge;
			assign cur      = {p_rem[j], p_lo[j][QUO_W-1]};
			assign diff     = cur - {1'b0, p_den};
			assign ge       = (cur >= {1'b0, p_den});
			assign n_rem[j] = ge ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
			assign n_lo[j]  = {p_lo[j][QUO_W-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else begin
				valid_s[i] <= p_valid;
			end
		end

		always_ff @(posedge clk) begin
			den_s[i] <= p_den;
			tag_s[i] <= p_tag;
			rem_s[i] <= n_rem;
			lo_s[i]  <= n_lo;
		end
	end

	assign quo_valid = valid_s[QUO_W-1];
	assign quo       = lo_s[QUO_W-1];
	assign quo_tag   = tag_s[QUO_W-1];

endmodule

`default_nettype wire

### rtl/central_gravity_particle_step.sv
// Top level of the central gravity particle step pipeline.
// Depends on cgps_pkg, cgps_cfg, cgps_isqrt and cgps_div.
//
// Usage:
//   Raise start with one particle on the particle port; it is taken at that edge
//   whenever busy is low. busy stays low: the pipeline takes one item per clock.
//   Each item yields one result, shown on result for one cycle with done high,
//   in the order the items came in. The receiver cannot stall; the pipeline
//   never holds.
//   The pipeline is made of 3 front stages (offset, squares, sum), 25 square-root
//   stages, 1 stage for the distance floor and its square, 53 stages of the
//   gravity divide, 2 partial-product stages, 53 stages of the per-axis divide
//   by distance, and 3 back stages (velocity, velocity times dt, position).
//   The two bit-per-stage dividers set most of that depth.
//   Registers sit on the APB port; the user must write them only while no item
//   is in flight, as the block does not enforce it. Reset clears all valid bits
//   and loads the register reset values; items in flight are dropped.
`default_nettype none

module central_gravity_particle_step (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire cgps_pkg::particle_t         particle,
	output logic                             done,
	output cgps_pkg::result_t                result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [cgps_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	localparam int CTX_W = $bits(cgps_pkg::ctx_t);

	cgps_pkg::cfg_t cfg;

	cgps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign busy = 1'b0;

	logic [cgps_pkg::GRAV_W-1:0] grav_q;

	always_ff @(posedge clk) begin
		grav_q <= cfg.pull_strength * cfg.time_step;
	end

	// stage 1: offsets, magnitudes, lifetime
	logic signed [24:0] dx_c, dy_c;
	logic [24:0]        ndx_c, ndy_c;
	logic [25:0]        ts_ext;
	cgps_pkg::ctx_t     ctx_c;

	always_comb begin
		dx_c   = $signed({cfg.center_x[23], cfg.center_x}) -
			$signed({particle.pos_x[23], particle.pos_x});
		dy_c   = $signed({cfg.center_y[23], cfg.center_y}) -
			$signed({particle.pos_y[23], particle.pos_y});
		ndx_c  = -dx_c;
		ndy_c  = -dy_c;
		ts_ext = {13'd0, cfg.time_step};
		ctx_c.pos_x = particle.pos_x;
		ctx_c.pos_y = particle.pos_y;
		ctx_c.vel_x = particle.vel_x;
		ctx_c.vel_y = particle.vel_y;
		ctx_c.life  = (particle.life_left > ts_ext) ? (particle.life_left - ts_ext) : 26'd0;
		ctx_c.neg_x = dx_c[24];
		ctx_c.neg_y = dy_c[24];
		ctx_c.mag_x = dx_c[24] ? ndx_c[23:0] : dx_c[23:0];
		ctx_c.mag_y = dy_c[24] ? ndy_c[23:0] : dy_c[23:0];
		ctx_c.radius = '0;
	end

	logic           valid_s1, valid_s2, valid_s3;
	cgps_pkg::ctx_t ctx_s1, ctx_s2, ctx_s3;
	logic [47:0]    sqx_s2, sqy_s2;
	logic [48:0]    sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s1 <= ctx_c;
		ctx_s2 <= ctx_s1;
		sqx_s2 <= ctx_s1.mag_x * ctx_s1.mag_x;
		sqy_s2 <= ctx_s1.mag_y * ctx_s1.mag_y;
		ctx_s3 <= ctx_s2;
		sum_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
	end

	logic                        sq_valid;
	logic [cgps_pkg::DIST_W-1:0] sq_root;
	logic [CTX_W-1:0]            sq_tag;

	cgps_isqrt #(
		.IN_W  (cgps_pkg::SQ_W),
		.PAY_W (CTX_W)
	) u_isqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s3),
		.sq         ({1'b0, sum_s3}),
		.tag        (ctx_s3),
		.root_valid (sq_valid),
		.root       (sq_root),
		.root_tag   (sq_tag)
	);

	// stage 4: distance floor, capture, squared distance
	logic [cgps_pkg::DIST_W-1:0] dist_c;
	logic [cgps_pkg::DIST_W-1:0] horizon_c;
	cgps_pkg::ctx_t              ctx4_c;

	always_comb begin
		dist_c        = (sq_root < cgps_pkg::DIST_MIN) ? cgps_pkg::DIST_MIN : sq_root;
		horizon_c     = {7'd0, cfg.horizon_radius, 8'd0};
		ctx4_c        = sq_tag;
		ctx4_c.radius = dist_c;
		if (dist_c < horizon_c) begin
			ctx4_c.life = '0;
		end
	end

	logic                            valid_s4;
	cgps_pkg::ctx_t                  ctx_s4;
	logic [cgps_pkg::SQ_W-1:0]       rsq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s4 <= ctx4_c;
		rsq_s4 <= dist_c * dist_c;
	end

	localparam int GNUM_W = cgps_pkg::GRAV_W + cgps_pkg::GRAV_SH;

	logic                         gq_valid;
	logic [0:0][cgps_pkg::QUO_W-1:0] gq_quo;
	logic [CTX_W-1:0]             gq_tag;
	logic [0:0][GNUM_W-1:0]       gnum;

	assign gnum[0] = {grav_q, {cgps_pkg::GRAV_SH{1'b0}}};

	cgps_div #(
		.NUM_W (GNUM_W),
		.DEN_W (cgps_pkg::SQ_W),
		.QUO_W (cgps_pkg::QUO_W),
		.LANES (1),
		.PAY_W (CTX_W)
	) u_div_grav (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s4),
		.num        (gnum),
		.den        (rsq_s4),
		.tag        (ctx_s4),
		.quo_valid  (gq_valid),
		.quo        (gq_quo),
		.quo_tag    (gq_tag)
	);

	// stages 5 and 6: q times magnitude in two partial products
	cgps_pkg::ctx_t gq_ctx;
	assign gq_ctx = gq_tag;

	localparam int QHI_W = cgps_pkg::QUO_W - cgps_pkg::QLO_W;

	logic                   valid_s5, valid_s6;
	cgps_pkg::ctx_t         ctx_s5, ctx_s6;
	logic [50:0]            pplo_x_s5, pplo_y_s5;
	logic [49:0]            pphi_x_s5, pphi_y_s5;
	logic [76:0]            prod_x_c, prod_y_c;
	logic [cgps_pkg::MNUM_W-1:0] num_x_s6, num_y_s6;

	always_comb begin
		prod_x_c = {26'd0, pplo_x_s5} + {pphi_x_s5, {cgps_pkg::QLO_W{1'b0}}};
		prod_y_c = {26'd0, pplo_y_s5} + {pphi_y_s5, {cgps_pkg::QLO_W{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s5 <= gq_valid;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s5    <= gq_ctx;
		pplo_x_s5 <= gq_quo[0][cgps_pkg::QLO_W-1:0] * gq_ctx.mag_x;
		pplo_y_s5 <= gq_quo[0][cgps_pkg::QLO_W-1:0] * gq_ctx.mag_y;
		pphi_x_s5 <= gq_quo[0][cgps_pkg::QUO_W-1 -: QHI_W] * gq_ctx.mag_x;
		pphi_y_s5 <= gq_quo[0][cgps_pkg::QUO_W-1 -: QHI_W] * gq_ctx.mag_y;
		ctx_s6    <= ctx_s5;
		num_x_s6  <= prod_x_c[cgps_pkg::MNUM_W-1:0];
		num_y_s6  <= prod_y_c[cgps_pkg::MNUM_W-1:0];
	end

	logic [1:0][cgps_pkg::MNUM_W-1:0] mnum;
	logic                             mq_valid;
	logic [1:0][cgps_pkg::QUO_W-1:0]  mq_quo;
	logic [CTX_W-1:0]                 mq_tag;

	assign mnum[0] = num_x_s6;
	assign mnum[1] = num_y_s6;

	cgps_div #(
		.NUM_W (cgps_pkg::MNUM_W),
		.DEN_W (cgps_pkg::DIST_W),
		.QUO_W (cgps_pkg::QUO_W),
		.LANES (2),
		.PAY_W (CTX_W)
	) u_div_axis (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s6),
		.num        (mnum),
		.den        (ctx_s6.radius),
		.tag        (ctx_s6),
		.quo_valid  (mq_valid),
		.quo        (mq_quo),
		.quo_tag    (mq_tag)
	);

	// stages 7 to 9: velocity, velocity times dt, position
	cgps_pkg::ctx_t mq_ctx;
	assign mq_ctx = mq_tag;

	logic               valid_s7, valid_s8, valid_s9;
	cgps_pkg::ctx_t     ctx_s7, ctx_s8;
	logic signed [23:0] nv_x_s7, nv_y_s7, nv_x_s8, nv_y_s8;
	logic [23:0]        mag_vx_c, mag_vy_c, neg_vx_c, neg_vy_c;
	logic [36:0]        prod_x_s8, prod_y_s8;
	cgps_pkg::result_t  result_c, result_s9;

	always_comb begin
		neg_vx_c = -nv_x_s7;
		neg_vy_c = -nv_y_s7;
		mag_vx_c = nv_x_s7[23] ? neg_vx_c : nv_x_s7;
		mag_vy_c = nv_y_s7[23] ? neg_vy_c : nv_y_s7;
		result_c.new_vel_x = nv_x_s8;
		result_c.new_vel_y = nv_y_s8;
		result_c.new_pos_x = cgps_pkg::pos_step(prod_x_s8, nv_x_s8[23], ctx_s8.pos_x);
		result_c.new_pos_y = cgps_pkg::pos_step(prod_y_s8, nv_y_s8[23], ctx_s8.pos_y);
		result_c.new_life  = ctx_s8.life;
		result_c.alive     = (ctx_s8.life != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			valid_s7 <= mq_valid;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s7    <= mq_ctx;
		nv_x_s7   <= cgps_pkg::vel_step(mq_quo[0], mq_ctx.neg_x, mq_ctx.vel_x);
		nv_y_s7   <= cgps_pkg::vel_step(mq_quo[1], mq_ctx.neg_y, mq_ctx.vel_y);
		ctx_s8    <= ctx_s7;
		nv_x_s8   <= nv_x_s7;
		nv_y_s8   <= nv_y_s7;
		prod_x_s8 <= mag_vx_c * cfg.time_step;
		prod_y_s8 <= mag_vy_c * cfg.time_step;
		result_s9 <= result_c;
	end

	assign done   = valid_s9;
	assign result = result_s9;

endmodule

`default_nettype wire
